// ----- hw/rtl/tadj_pkg.sv -----
// ----------------------------------------------------------------------------
// tadj_pkg
// Types, constants and helper functions for the trapezoid adjacency test.
// ----------------------------------------------------------------------------
package tadj_pkg;

  localparam int CW       = 16;
  localparam int TOL_BITS = 4;

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(1);

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef logic [CW-1:0]   coord_t;
  typedef logic [2*CW-1:0] wide_t;
  typedef logic [3*CW-1:0] prod_t;

  typedef struct packed {
    coord_t a_l, a_r, a_lt, a_rt, a_lb, a_rb;
    coord_t b_l, b_r, b_lt, b_rt, b_lb, b_rb;
  } pair_t;

  // wall results, carried unchanged to stage 4
  typedef struct packed {
    logic       hit;
    logic [1:0] dir;
    coord_t     x;
    coord_t     y1;
    coord_t     y2;
  } wall_t;

  // A's ceiling and floor corners plus span
  typedef struct packed {
    coord_t lt, rt, lb, rb;
    coord_t da;
  } aroom_t;

  typedef struct packed {
    logic  valid;
    wall_t wall;
    logic  ov;
    coord_t x1, x2;
    coord_t db;
    aroom_t a;
    coord_t ta1, ta2;                 // x - a_l
    coord_t ra1, ra2;                 // a_r - x
    coord_t tb1, tb2;                 // x - b_l
    coord_t rb1, rb2;                 // b_r - x
    coord_t b_lt, b_rt, b_lb, b_rb;
  } s1_t;

  typedef struct packed {
    logic   valid;
    wall_t  wall;
    logic   ov;
    coord_t x1, x2;
    coord_t db;
    aroom_t a;
    coord_t ta1, ta2;
    wide_t  nac1, nac2, naf1, naf2, nbc1, nbc2, nbf1, nbf2;
    wide_t  dadb;
  } s2_t;

  typedef struct packed {
    logic   valid;
    wall_t  wall;
    logic   ov;
    coord_t x1, x2;
    aroom_t a;
    coord_t ta1, ta2;
    prod_t  pu1, pu2, qu1, qu2, pd1, pd2, qd1, qd2;
    prod_t  tt;
  } s3_t;

  // control carried through the divider
  typedef struct packed {
    logic       valid;
    logic       hit;
    logic [1:0] dir;
    logic       fl;
    coord_t     fx, sx, fyw, syw;
    coord_t     yl;
    logic       neg;
    coord_t     d;
  } ctl_t;

  typedef struct packed {
    ctl_t   ctl;
    coord_t diff;
    coord_t t1, t2;
  } s4_t;

  typedef struct packed {
    coord_t rem;
    coord_t nlo;
    coord_t q;
  } div_t;

  function automatic div_t div_step(div_t s, coord_t d);
    logic [CW:0] t;
    div_t        r;
    t = {s.rem, s.nlo[CW-1]};
    r = s;
    if (t >= {1'b0, d}) begin
      r.rem = CW'(t - {1'b0, d});
      r.q   = {s.q[CW-2:0], 1'b1};
    end else begin
      r.rem = t[CW-1:0];
      r.q   = {s.q[CW-2:0], 1'b0};
    end
    r.nlo = {s.nlo[CW-2:0], 1'b0};
    return r;
  endfunction

  function automatic div_t div_init(wide_t n);
    div_t r;
    r.rem = n[2*CW-1:CW];
    r.nlo = n[CW-1:0];
    r.q   = '0;
    return r;
  endfunction

  function automatic coord_t round_y(coord_t yl, logic neg, coord_t q, coord_t rem,
                                     coord_t d);
    coord_t half;
    logic   bump;
    half = d - rem;
    bump = neg ? (rem > half) : (rem >= half);
    return neg ? yl - q - {{(CW-1){1'b0}}, bump} : yl + q + {{(CW-1){1'b0}}, bump};
  endfunction

  function automatic logic close_enough(prod_t p, prod_t q, prod_t t);
    logic [3*CW:0] qt, pt;
    qt = {1'b0, q} + {1'b0, t};
    pt = {1'b0, p} + {1'b0, t};
    return ({1'b0, p} <= qt) && ({1'b0, q} <= pt);
  endfunction

endpackage

// ----- hw/rtl/trapezoid_adjacency_test.sv -----
// ----------------------------------------------------------------------------
// trapezoid_adjacency_test
// Tests whether two wall-vertical trapezoid rooms touch and reports the
// shared segment.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the twelve in_* coordinates and pulse start. A word is
//   taken at every clock edge with start high; busy is always low, so a
//   new pair can be issued every cycle.
//   Output: out_valid is high for one cycle with the result word for each
//   pair, in issue order. The receiver cannot stall and needs none.
//   Pipeline: the input register, five stages of compare and multiply, the
//   bit-per-stage rounding divider and the output register; throughput one
//   pair per cycle.
//   Config: cfg_data (match tolerance) is written when cfg_valid is high;
//   cfg_ready is always high. Write only while the pipeline is empty.
//   Reset: rst_n low at a clock edge flushes all words in flight and sets
//   the tolerance to 1.
// ----------------------------------------------------------------------------
module trapezoid_adjacency_test (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  tadj_pkg::coord_t              in_a_left,
  input  tadj_pkg::coord_t              in_a_right,
  input  tadj_pkg::coord_t              in_a_left_top,
  input  tadj_pkg::coord_t              in_a_right_top,
  input  tadj_pkg::coord_t              in_a_left_bottom,
  input  tadj_pkg::coord_t              in_a_right_bottom,
  input  tadj_pkg::coord_t              in_b_left,
  input  tadj_pkg::coord_t              in_b_right,
  input  tadj_pkg::coord_t              in_b_left_top,
  input  tadj_pkg::coord_t              in_b_right_top,
  input  tadj_pkg::coord_t              in_b_left_bottom,
  input  tadj_pkg::coord_t              in_b_right_bottom,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tadj_pkg::TOL_BITS-1:0] cfg_data,
  output logic                          out_valid,
  output logic                          out_is_adjacent,
  output logic [1:0]                    out_direction,
  output tadj_pkg::coord_t              out_first_x,
  output tadj_pkg::coord_t              out_first_y,
  output tadj_pkg::coord_t              out_second_x,
  output tadj_pkg::coord_t              out_second_y
);

  localparam int CW = tadj_pkg::CW;

  logic [tadj_pkg::TOL_BITS-1:0] tol_r;

  logic            s0_valid_r;
  tadj_pkg::pair_t s0_r;
  tadj_pkg::s1_t   s1_r, s1_nxt;
  tadj_pkg::s2_t   s2_r, s2_nxt;
  tadj_pkg::s3_t   s3_r, s3_nxt;
  tadj_pkg::s4_t   s4_r, s4_nxt;
  tadj_pkg::ctl_t  s5_ctl_r, s5_ctl_nxt;
  tadj_pkg::wide_t s5_n1_r, s5_n2_r;

  tadj_pkg::ctl_t  dctl_r   [CW];
  tadj_pkg::ctl_t  dctl_nxt [CW];
  tadj_pkg::div_t  dv1_r    [CW];
  tadj_pkg::div_t  dv2_r    [CW];

  logic             out_valid_r, out_hit_r;
  logic [1:0]       out_dir_r;
  tadj_pkg::coord_t out_fx_r, out_fy_r, out_sx_r, out_sy_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= tadj_pkg::TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  // stage 0: input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start;
    end
    s0_r <= '{in_a_left, in_a_right, in_a_left_top, in_a_right_top,
              in_a_left_bottom, in_a_right_bottom, in_b_left, in_b_right,
              in_b_left_top, in_b_right_top, in_b_left_bottom, in_b_right_bottom};
  end

  // stage 1: wall tests, overlap span, distances
  always_comb begin
    tadj_pkg::coord_t ly1, ly2, ry1, ry2;
    logic             lhit, rhit;
    ly1  = (s0_r.a_lt > s0_r.b_rt) ? s0_r.a_lt : s0_r.b_rt;
    ly2  = (s0_r.a_lb < s0_r.b_rb) ? s0_r.a_lb : s0_r.b_rb;
    ry1  = (s0_r.a_rt > s0_r.b_lt) ? s0_r.a_rt : s0_r.b_lt;
    ry2  = (s0_r.a_rb < s0_r.b_lb) ? s0_r.a_rb : s0_r.b_lb;
    lhit = (ly2 > ly1) && (s0_r.a_l == s0_r.b_r);
    rhit = (ry2 > ry1) && (s0_r.a_r == s0_r.b_l);
    s1_nxt.valid    = rst_n && s0_valid_r;
    s1_nxt.wall.hit = lhit || rhit;
    if (lhit) begin
      s1_nxt.wall.dir = tadj_pkg::DIR_LEFT;
      s1_nxt.wall.x   = s0_r.a_l;
      s1_nxt.wall.y1  = ly1;
      s1_nxt.wall.y2  = ly2;
    end else begin
      s1_nxt.wall.dir = tadj_pkg::DIR_RIGHT;
      s1_nxt.wall.x   = s0_r.a_r;
      s1_nxt.wall.y1  = ry1;
      s1_nxt.wall.y2  = ry2;
    end
    s1_nxt.x1   = (s0_r.a_l > s0_r.b_l) ? s0_r.a_l : s0_r.b_l;
    s1_nxt.x2   = (s0_r.a_r < s0_r.b_r) ? s0_r.a_r : s0_r.b_r;
    s1_nxt.ov   = s1_nxt.x2 > s1_nxt.x1;
    s1_nxt.db   = s0_r.b_r - s0_r.b_l;
    s1_nxt.a.lt = s0_r.a_lt;
    s1_nxt.a.rt = s0_r.a_rt;
    s1_nxt.a.lb = s0_r.a_lb;
    s1_nxt.a.rb = s0_r.a_rb;
    s1_nxt.a.da = s0_r.a_r - s0_r.a_l;
    s1_nxt.ta1  = s1_nxt.x1 - s0_r.a_l;
    s1_nxt.ta2  = s1_nxt.x2 - s0_r.a_l;
    s1_nxt.ra1  = s0_r.a_r - s1_nxt.x1;
    s1_nxt.ra2  = s0_r.a_r - s1_nxt.x2;
    s1_nxt.tb1  = s1_nxt.x1 - s0_r.b_l;
    s1_nxt.tb2  = s1_nxt.x2 - s0_r.b_l;
    s1_nxt.rb1  = s0_r.b_r - s1_nxt.x1;
    s1_nxt.rb2  = s0_r.b_r - s1_nxt.x2;
    s1_nxt.b_lt = s0_r.b_lt;
    s1_nxt.b_rt = s0_r.b_rt;
    s1_nxt.b_lb = s0_r.b_lb;
    s1_nxt.b_rb = s0_r.b_rb;
  end

  // stage 2: line heights scaled by room width
  function automatic tadj_pkg::wide_t lnum(tadj_pkg::coord_t yl, tadj_pkg::coord_t yr,
                                           tadj_pkg::coord_t rx, tadj_pkg::coord_t xl);
    logic [2*CW:0] s;
    s = {1'b0, tadj_pkg::wide_t'(yl) * tadj_pkg::wide_t'(rx)} +
        {1'b0, tadj_pkg::wide_t'(yr) * tadj_pkg::wide_t'(xl)};
    return s[2*CW-1:0];
  endfunction

  always_comb begin
    s2_nxt.valid = rst_n && s1_r.valid;
    s2_nxt.wall  = s1_r.wall;
    s2_nxt.ov    = s1_r.ov;
    s2_nxt.x1    = s1_r.x1;
    s2_nxt.x2    = s1_r.x2;
    s2_nxt.db    = s1_r.db;
    s2_nxt.a     = s1_r.a;
    s2_nxt.ta1   = s1_r.ta1;
    s2_nxt.ta2   = s1_r.ta2;
    s2_nxt.nac1  = lnum(s1_r.a.lt, s1_r.a.rt, s1_r.ra1, s1_r.ta1);
    s2_nxt.nac2  = lnum(s1_r.a.lt, s1_r.a.rt, s1_r.ra2, s1_r.ta2);
    s2_nxt.naf1  = lnum(s1_r.a.lb, s1_r.a.rb, s1_r.ra1, s1_r.ta1);
    s2_nxt.naf2  = lnum(s1_r.a.lb, s1_r.a.rb, s1_r.ra2, s1_r.ta2);
    s2_nxt.nbc1  = lnum(s1_r.b_lt, s1_r.b_rt, s1_r.rb1, s1_r.tb1);
    s2_nxt.nbc2  = lnum(s1_r.b_lt, s1_r.b_rt, s1_r.rb2, s1_r.tb2);
    s2_nxt.nbf1  = lnum(s1_r.b_lb, s1_r.b_rb, s1_r.rb1, s1_r.tb1);
    s2_nxt.nbf2  = lnum(s1_r.b_lb, s1_r.b_rb, s1_r.rb2, s1_r.tb2);
    s2_nxt.dadb  = s1_r.a.da * s1_r.db;
  end

  // stage 3: cross scaling to a common denominator
  always_comb begin
    s3_nxt.valid = rst_n && s2_r.valid;
    s3_nxt.wall  = s2_r.wall;
    s3_nxt.ov    = s2_r.ov;
    s3_nxt.x1    = s2_r.x1;
    s3_nxt.x2    = s2_r.x2;
    s3_nxt.a     = s2_r.a;
    s3_nxt.ta1   = s2_r.ta1;
    s3_nxt.ta2   = s2_r.ta2;
    s3_nxt.pu1   = s2_r.nac1 * s2_r.db;
    s3_nxt.pu2   = s2_r.nac2 * s2_r.db;
    s3_nxt.qu1   = s2_r.nbf1 * s2_r.a.da;
    s3_nxt.qu2   = s2_r.nbf2 * s2_r.a.da;
    s3_nxt.pd1   = s2_r.naf1 * s2_r.db;
    s3_nxt.pd2   = s2_r.naf2 * s2_r.db;
    s3_nxt.qd1   = s2_r.nbc1 * s2_r.a.da;
    s3_nxt.qd2   = s2_r.nbc2 * s2_r.a.da;
    s3_nxt.tt    = tadj_pkg::prod_t'(s2_r.dadb) * tadj_pkg::prod_t'(tol_r);
  end

  // stage 4: tolerance compares, pick result and line to round
  always_comb begin
    logic up, dn, fhit;
    up   = tadj_pkg::close_enough(s3_r.pu1, s3_r.qu1, s3_r.tt) &&
           tadj_pkg::close_enough(s3_r.pu2, s3_r.qu2, s3_r.tt);
    dn   = tadj_pkg::close_enough(s3_r.pd1, s3_r.qd1, s3_r.tt) &&
           tadj_pkg::close_enough(s3_r.pd2, s3_r.qd2, s3_r.tt);
    fhit = !s3_r.wall.hit && s3_r.ov && (up || dn);
    s4_nxt.ctl.valid = rst_n && s3_r.valid;
    s4_nxt.ctl.hit   = s3_r.wall.hit || fhit;
    s4_nxt.ctl.fl    = fhit;
    if (s3_r.wall.hit) begin
      s4_nxt.ctl.dir = s3_r.wall.dir;
    end else if (fhit) begin
      s4_nxt.ctl.dir = up ? tadj_pkg::DIR_UP : tadj_pkg::DIR_DOWN;
    end else begin
      s4_nxt.ctl.dir = tadj_pkg::DIR_LEFT;
    end
    s4_nxt.ctl.fx  = s3_r.wall.hit ? s3_r.wall.x  : (fhit ? s3_r.x1 : '0);
    s4_nxt.ctl.sx  = s3_r.wall.hit ? s3_r.wall.x  : (fhit ? s3_r.x2 : '0);
    s4_nxt.ctl.fyw = s3_r.wall.hit ? s3_r.wall.y1 : '0;
    s4_nxt.ctl.syw = s3_r.wall.hit ? s3_r.wall.y2 : '0;
    s4_nxt.ctl.yl  = up ? s3_r.a.lt : s3_r.a.lb;
    s4_nxt.ctl.neg = up ? (s3_r.a.rt < s3_r.a.lt) : (s3_r.a.rb < s3_r.a.lb);
    s4_nxt.ctl.d   = s3_r.a.da;
    if (up) begin
      s4_nxt.diff = s4_nxt.ctl.neg ? s3_r.a.lt - s3_r.a.rt : s3_r.a.rt - s3_r.a.lt;
    end else begin
      s4_nxt.diff = s4_nxt.ctl.neg ? s3_r.a.lb - s3_r.a.rb : s3_r.a.rb - s3_r.a.lb;
    end
    s4_nxt.t1 = s3_r.ta1;
    s4_nxt.t2 = s3_r.ta2;
  end

  // control words for stage 5 and the divider, flushed by reset
  always_comb begin
    s5_ctl_nxt        = s4_r.ctl;
    s5_ctl_nxt.valid  = rst_n && s4_r.ctl.valid;
    dctl_nxt[0]       = s5_ctl_r;
    dctl_nxt[0].valid = rst_n && s5_ctl_r.valid;
    for (int k = 1; k < CW; k++) begin
      dctl_nxt[k]       = dctl_r[k-1];
      dctl_nxt[k].valid = rst_n && dctl_r[k-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
    s4_r <= s4_nxt;
    // stage 5: rounding numerators
    s5_ctl_r <= s5_ctl_nxt;
    s5_n1_r  <= s4_r.diff * s4_r.t1;
    s5_n2_r  <= s4_r.diff * s4_r.t2;
  end

  // divider: one quotient bit per stage
  always_ff @(posedge clk) begin
    for (int k = 0; k < CW; k++) begin
      dctl_r[k] <= dctl_nxt[k];
    end
    dv1_r[0] <= tadj_pkg::div_step(tadj_pkg::div_init(s5_n1_r), s5_ctl_r.d);
    dv2_r[0] <= tadj_pkg::div_step(tadj_pkg::div_init(s5_n2_r), s5_ctl_r.d);
    for (int k = 1; k < CW; k++) begin
      dv1_r[k] <= tadj_pkg::div_step(dv1_r[k-1], dctl_r[k-1].d);
      dv2_r[k] <= tadj_pkg::div_step(dv2_r[k-1], dctl_r[k-1].d);
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dctl_r[CW-1].valid;
    end
    out_hit_r <= dctl_r[CW-1].hit;
    out_dir_r <= dctl_r[CW-1].dir;
    out_fx_r  <= dctl_r[CW-1].fx;
    out_sx_r  <= dctl_r[CW-1].sx;
    if (dctl_r[CW-1].fl) begin
      out_fy_r <= tadj_pkg::round_y(dctl_r[CW-1].yl, dctl_r[CW-1].neg, dv1_r[CW-1].q,
                                    dv1_r[CW-1].rem, dctl_r[CW-1].d);
      out_sy_r <= tadj_pkg::round_y(dctl_r[CW-1].yl, dctl_r[CW-1].neg, dv2_r[CW-1].q,
                                    dv2_r[CW-1].rem, dctl_r[CW-1].d);
    end else begin
      out_fy_r <= dctl_r[CW-1].fyw;
      out_sy_r <= dctl_r[CW-1].syw;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_adjacent = out_hit_r;
  assign out_direction   = out_dir_r;
  assign out_first_x     = out_fx_r;
  assign out_first_y     = out_fy_r;
  assign out_second_x    = out_sx_r;
  assign out_second_y    = out_sy_r;

  // no contact gives an all-zero word
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_adjacent |->
      out_direction == tadj_pkg::DIR_LEFT && out_first_x == '0 && out_second_x == '0 &&
      out_first_y == '0 && out_second_y == '0)
    else $error("miss word not zero");

  // a wall contact is a vertical segment running downwards
  a_wall_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_adjacent &&
    (out_direction == tadj_pkg::DIR_LEFT || out_direction == tadj_pkg::DIR_RIGHT) |->
      out_first_x == out_second_x && out_first_y < out_second_y)
    else $error("bad wall segment");

  // a floor or ceiling contact spans a strict x interval
  a_flat_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_adjacent &&
    (out_direction == tadj_pkg::DIR_UP || out_direction == tadj_pkg::DIR_DOWN) |->
      out_first_x < out_second_x)
    else $error("bad floor segment");

  // every result word was requested by an accepted start
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, CW + 7))
    else $error("result without request");

endmodule

// ----- verif/trapezoid_adjacency_test_tb.sv -----
// ----------------------------------------------------------------------------
// trapezoid_adjacency_test_tb
// Streams room pairs through the adjacency test with random start gaps and
// checks every result word against an exact rational-arithmetic predictor.
// ----------------------------------------------------------------------------
module trapezoid_adjacency_test_tb;

  localparam int LATENCY   = 7 + tadj_pkg::CW;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic             adj;
    logic [1:0]       dir;
    tadj_pkg::coord_t fx, fy, sx, sy;
  } contact_t;

  logic             clk, rst_n, start, busy;
  tadj_pkg::pair_t  cur;
  logic             cfg_valid, cfg_ready;
  logic [tadj_pkg::TOL_BITS-1:0] cfg_data;
  logic             out_valid, out_is_adjacent;
  logic [1:0]       out_direction;
  tadj_pkg::coord_t out_first_x, out_first_y, out_second_x, out_second_y;

  tadj_pkg::pair_t  pending_pairs[$];
  contact_t         expected_contacts[$];
  logic [tadj_pkg::TOL_BITS-1:0] tolerance;
  int               errors, checked, adj_count, cycle, gap;
  int               dir_hits[4];

  trapezoid_adjacency_test DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_left(cur.a_l), .in_a_right(cur.a_r),
    .in_a_left_top(cur.a_lt), .in_a_right_top(cur.a_rt),
    .in_a_left_bottom(cur.a_lb), .in_a_right_bottom(cur.a_rb),
    .in_b_left(cur.b_l), .in_b_right(cur.b_r),
    .in_b_left_top(cur.b_lt), .in_b_right_top(cur.b_rt),
    .in_b_left_bottom(cur.b_lb), .in_b_right_bottom(cur.b_rb),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_is_adjacent(out_is_adjacent),
    .out_direction(out_direction), .out_first_x(out_first_x),
    .out_first_y(out_first_y), .out_second_x(out_second_x),
    .out_second_y(out_second_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // line height at x times (r - l)
  function automatic logic [63:0] line_scaled(tadj_pkg::coord_t yl, tadj_pkg::coord_t yr,
                                              tadj_pkg::coord_t l, tadj_pkg::coord_t r,
                                              tadj_pkg::coord_t x);
    return 64'(yl) * 64'(r - x) + 64'(yr) * 64'(x - l);
  endfunction

  function automatic tadj_pkg::coord_t height_rounded(tadj_pkg::coord_t yl,
                                                      tadj_pkg::coord_t yr,
                                                      tadj_pkg::coord_t l,
                                                      tadj_pkg::coord_t r,
                                                      tadj_pkg::coord_t x);
    logic [63:0] d, num, q, rem;
    d = 64'(r - l);
    if (yr >= yl) begin
      num = 64'(yr - yl) * 64'(x - l);
      q = num / d;
      rem = num % d;
      return tadj_pkg::coord_t'(64'(yl) + q + ((rem >= d - rem) ? 64'd1 : 64'd0));
    end
    num = 64'(yl - yr) * 64'(x - l);
    q = num / d;
    rem = num % d;
    return tadj_pkg::coord_t'(64'(yl) - q - ((rem > d - rem) ? 64'd1 : 64'd0));
  endfunction

  function automatic logic edges_touch(tadj_pkg::coord_t ayl, tadj_pkg::coord_t ayr,
                                       tadj_pkg::coord_t al, tadj_pkg::coord_t ar,
                                       tadj_pkg::coord_t byl, tadj_pkg::coord_t byr,
                                       tadj_pkg::coord_t bl, tadj_pkg::coord_t br,
                                       tadj_pkg::coord_t x);
    logic [127:0] p, q, t;
    p = 128'(line_scaled(ayl, ayr, al, ar, x)) * 128'(br - bl);
    q = 128'(line_scaled(byl, byr, bl, br, x)) * 128'(ar - al);
    t = 128'(ar - al) * 128'(br - bl) * 128'(tolerance);
    return (p <= q + t) && (q <= p + t);
  endfunction

  function automatic contact_t find_contact(tadj_pkg::pair_t p);
    contact_t         c;
    tadj_pkg::coord_t y1, y2, x1, x2;
    c = '0;
    y1 = p.a_lt > p.b_rt ? p.a_lt : p.b_rt;
    y2 = p.a_lb < p.b_rb ? p.a_lb : p.b_rb;
    if (y2 > y1 && p.a_l == p.b_r) begin
      c = '{1'b1, tadj_pkg::DIR_LEFT, p.a_l, y1, p.a_l, y2};
      return c;
    end
    y1 = p.a_rt > p.b_lt ? p.a_rt : p.b_lt;
    y2 = p.a_rb < p.b_lb ? p.a_rb : p.b_lb;
    if (y2 > y1 && p.a_r == p.b_l) begin
      c = '{1'b1, tadj_pkg::DIR_RIGHT, p.a_r, y1, p.a_r, y2};
      return c;
    end
    x1 = p.a_l > p.b_l ? p.a_l : p.b_l;
    x2 = p.a_r < p.b_r ? p.a_r : p.b_r;
    if (x2 > x1) begin
      if (edges_touch(p.a_lt, p.a_rt, p.a_l, p.a_r, p.b_lb, p.b_rb, p.b_l, p.b_r, x1) &&
          edges_touch(p.a_lt, p.a_rt, p.a_l, p.a_r, p.b_lb, p.b_rb, p.b_l, p.b_r, x2))
        c = '{1'b1, tadj_pkg::DIR_UP, x1, height_rounded(p.a_lt, p.a_rt, p.a_l, p.a_r, x1),
              x2, height_rounded(p.a_lt, p.a_rt, p.a_l, p.a_r, x2)};
      else if (edges_touch(p.a_lb, p.a_rb, p.a_l, p.a_r, p.b_lt, p.b_rt, p.b_l, p.b_r, x1)
               && edges_touch(p.a_lb, p.a_rb, p.a_l, p.a_r, p.b_lt, p.b_rt, p.b_l,
                              p.b_r, x2))
        c = '{1'b1, tadj_pkg::DIR_DOWN, x1,
              height_rounded(p.a_lb, p.a_rb, p.a_l, p.a_r, x1),
              x2, height_rounded(p.a_lb, p.a_rb, p.a_l, p.a_r, x2)};
    end
    return c;
  endfunction

  function automatic tadj_pkg::coord_t rnd_coord();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return tadj_pkg::coord_t'($urandom_range(0, 20));
      3: return tadj_pkg::coord_t'(65535 - $urandom_range(0, 20));
      default: return tadj_pkg::coord_t'($urandom);
    endcase
  endfunction

  // rooms placed to touch, with jitter of up to 3 units
  function automatic tadj_pkg::pair_t make_touching(int kind);
    tadj_pkg::pair_t  p;
    int               w, h, j;
    tadj_pkg::coord_t base;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30000) : $urandom_range(1, 300);
    h = $urandom_range(1, 400);
    base = tadj_pkg::coord_t'($urandom_range(0, 30000));
    j = $urandom_range(0, 6);
    p.a_l = tadj_pkg::coord_t'($urandom_range(0, 30000));
    p.a_r = p.a_l + tadj_pkg::coord_t'(w);
    p.a_lt = base + tadj_pkg::coord_t'($urandom_range(0, 40));
    p.a_rt = base + tadj_pkg::coord_t'($urandom_range(0, 40));
    p.a_lb = p.a_lt + tadj_pkg::coord_t'(h);
    p.a_rb = p.a_rt + tadj_pkg::coord_t'($urandom_range(1, 400));
    p.b_lt = base + tadj_pkg::coord_t'($urandom_range(0, 300));
    p.b_rt = base + tadj_pkg::coord_t'($urandom_range(0, 300));
    p.b_lb = p.b_lt + tadj_pkg::coord_t'($urandom_range(1, 400));
    p.b_rb = p.b_rt + tadj_pkg::coord_t'($urandom_range(1, 400));
    case (kind)
      0: begin
        p.b_r = p.a_l;
        p.b_l = p.a_l - tadj_pkg::coord_t'($urandom_range(0, 300));
      end
      1: begin
        p.b_l = p.a_r;
        p.b_r = p.a_r + tadj_pkg::coord_t'($urandom_range(0, 300));
      end
      default: begin
        p.b_l = p.a_l + tadj_pkg::coord_t'($urandom_range(0, w)) -
                tadj_pkg::coord_t'($urandom_range(0, 50));
        p.b_r = p.b_l + tadj_pkg::coord_t'($urandom_range(1, 400));
        if (kind == 2) begin
          p.b_lb = p.a_lt + tadj_pkg::coord_t'(j) - tadj_pkg::coord_t'(3);
          p.b_rb = p.a_rt + tadj_pkg::coord_t'($urandom_range(0, 6)) -
                   tadj_pkg::coord_t'(3);
          p.b_lt = p.b_lb - tadj_pkg::coord_t'($urandom_range(1, 300));
          p.b_rt = p.b_rb - tadj_pkg::coord_t'($urandom_range(1, 300));
        end else begin
          p.b_lt = p.a_lb + tadj_pkg::coord_t'(j) - tadj_pkg::coord_t'(3);
          p.b_rt = p.a_rb + tadj_pkg::coord_t'($urandom_range(0, 6)) -
                   tadj_pkg::coord_t'(3);
        end
      end
    endcase
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH word %0d %s: got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  task automatic enqueue_pair(tadj_pkg::pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      if (pending_pairs.size() != 0 && $urandom_range(0, 3) != 0) begin
        cur <= pending_pairs.pop_front();
      end else begin
        start <= 1'b0;
        gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      end
    end else if (!start) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (pending_pairs.size() != 0) begin
        cur <= pending_pairs.pop_front();
        start <= 1'b1;
      end
    end
  end

  // predictor at acceptance and result check
  always @(posedge clk) begin
    contact_t want, got;
    if (rst_n) begin
      if (start && !busy) begin
        expected_contacts.insert(expected_contacts.size(), find_contact(cur));
      end
      if (cfg_valid && cfg_ready) tolerance = cfg_data;
      if (out_valid) begin
        got = '{out_is_adjacent, out_direction, out_first_x, out_first_y,
                out_second_x, out_second_y};
        if (expected_contacts.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = expected_contacts.pop_front();
          if (got.adj != want.adj) report_mismatch("is_adjacent", got.adj, want.adj);
          if (got.dir != want.dir) report_mismatch("direction", got.dir, want.dir);
          if (got.fx != want.fx) report_mismatch("first_x", got.fx, want.fx);
          if (got.fy != want.fy) report_mismatch("first_y", got.fy, want.fy);
          if (got.sx != want.sx) report_mismatch("second_x", got.sx, want.sx);
          if (got.sy != want.sy) report_mismatch("second_y", got.sy, want.sy);
          if (want.adj) begin
            adj_count++;
            dir_hits[want.dir]++;
          end
        end
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_tolerance(logic [tadj_pkg::TOL_BITS-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !start);
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    tadj_pkg::pair_t p;
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) begin
        p = make_touching($urandom_range(0, 3));
      end else begin
        p = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
             rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
      end
      enqueue_pair(p);
    end
  endtask

  logic [tadj_pkg::TOL_BITS-1:0] tol_plan[5] = '{4'd0, 4'd15, 4'd3, 4'd7, 4'd1};

  initial begin
    rst_n = 1'b0; start = 1'b0; cur = '0; cfg_valid = 1'b0; cfg_data = '0;
    gap = 0; errors = 0; checked = 0; adj_count = 0; cycle = 0;
    dir_hits = '{0, 0, 0, 0};
    tolerance = tadj_pkg::TOL_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed: walls, floors, ceilings, zero width, inverted, extremes
    enqueue_pair('0);
    enqueue_pair('1);
    enqueue_pair({16'd100, 16'd200, 16'd10, 16'd10, 16'd50, 16'd50,
                  16'd50, 16'd100, 16'd40, 16'd40, 16'd80, 16'd80});
    enqueue_pair({16'd100, 16'd200, 16'd10, 16'd10, 16'd50, 16'd50,
                  16'd200, 16'd300, 16'd40, 16'd40, 16'd80, 16'd80});
    enqueue_pair({16'd100, 16'd200, 16'd10, 16'd10, 16'd50, 16'd50,
                  16'd200, 16'd300, 16'd50, 16'd50, 16'd80, 16'd80});
    enqueue_pair({16'd0, 16'd3, 16'd10, 16'd11, 16'd50, 16'd50,
                  16'd1, 16'd4, 16'd0, 16'd0, 16'd10, 16'd11});
    enqueue_pair({16'd0, 16'd3, 16'd10, 16'd20, 16'd30, 16'd41,
                  16'd1, 16'd2, 16'd31, 16'd38, 16'd60, 16'd60});
    enqueue_pair({16'd7, 16'd7, 16'd10, 16'd10, 16'd30, 16'd30,
                  16'd7, 16'd7, 16'd0, 16'd0, 16'd10, 16'd10});
    enqueue_pair({16'd10, 16'd5, 16'd10, 16'd10, 16'd30, 16'd30,
                  16'd0, 16'd20, 16'd0, 16'd0, 16'd10, 16'd10});
    enqueue_pair({16'd0, 16'd65535, 16'd65535, 16'd0, 16'd65535, 16'd65535,
                  16'd0, 16'd65535, 16'd0, 16'd0, 16'd65534, 16'd1});
    enqueue_pair({16'd0, 16'd65535, 16'd0, 16'd0, 16'd1, 16'd65535,
                  16'd1, 16'd65535, 16'd2, 16'd65535, 16'd65535, 16'd65535});
    enqueue_pair({16'd0, 16'd2, 16'd10, 16'd11, 16'd20, 16'd20,
                  16'd0, 16'd2, 16'd0, 16'd0, 16'd10, 16'd11});
    enqueue_pair({16'd0, 16'd2, 16'd11, 16'd10, 16'd20, 16'd20,
                  16'd0, 16'd2, 16'd0, 16'd0, 16'd11, 16'd10});
    drain();
    foreach (tol_plan[i]) begin
      write_tolerance(tol_plan[i]);
      queue_random(290);
      drain();
    end
    $display("Checked %0d result words, %0d adjacent (left %0d right %0d up %0d down %0d)",
             checked, adj_count, dir_hits[0], dir_hits[1], dir_hits[2], dir_hits[3]);
    $display("Tolerances swept over 1, 0, 15, 3, 7 with random start gaps");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/tadj_pkg.sv
hw/rtl/trapezoid_adjacency_test.sv
verif/trapezoid_adjacency_test_tb.sv
